@@ design/bsc_pkg.sv @@
// Package with shared constants and helpers for the bus shadow change monitor.
`timescale 1ns / 1ps

package bsc_pkg;

   // Header byte layout: bus select on top, channel address below.
   localparam int unsigned BUS_BIT = 7;
   localparam int unsigned ADDR_W  = 7;

   // The programming status channel sits on the first bus at this address.
   localparam logic [ADDR_W-1:0] STATUS_ADDR = 7'd8;

   // Programming status codes reported on the status channel.
   typedef enum logic [2:0] {
      PROG_IDLE        = 3'd0,
      PROG_OK          = 3'd1,
      PROG_RANGE_ERROR = 3'd2,
      PROG_INDEX_ERROR = 3'd3,
      PROG_BUSY        = 3'd4
   } prog_status_type;

   // Map a status data byte to its code; unknown bytes read as idle.
   function automatic prog_status_type decode_status(input logic [7:0] data);
      prog_status_type code;
      case (data)
         8'd1:    code = PROG_OK;
         8'd2:    code = PROG_RANGE_ERROR;
         8'd3:    code = PROG_INDEX_ERROR;
         8'd4:    code = PROG_BUSY;
         default: code = PROG_IDLE;
      endcase
      return code;
   endfunction

endpackage

@@ design/bus_shadow_change_monitor.sv @@
// Top level of the bus shadow change monitor: byte pairing, shadow memory and result stage.
`timescale 1ns / 1ps

// Usage:
// The req channel carries one received monitor byte per item. Bytes alternate
// between a header (bit 7 selects the bus, bits 6..0 the channel address) and
// the data byte for that channel. A header item produces no result, and
// neither does a pair whose address is NUM_ADDRESSES or above.
// For every other pair one rsp item carries the bus, the address, the new
// value, the previously stored value with its known flag, a change flag and,
// for bus 0 address 8, the decoded programming status.
// The result of an accepted data byte passes the read stage, then the result
// register, before it is valid on rsp. Throughput is one byte per cycle while
// req_stall is low; the shadow memory is read and written in the same cycle,
// at the data byte's accept edge, so back-to-back pairs need no interlock.
// Reset clears the byte pairing (the next byte is a header) and marks every
// shadow entry unknown through a flop valid bit per entry.
// When the receiver stalls, the result register holds its item and the read
// stage holds one more; req_stall rises only when both are occupied.
module bus_shadow_change_monitor #(
   parameter int unsigned NUM_ADDRESSES = 112
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_bus_sel,
   output logic [6:0] rsp_address,
   output logic [7:0] rsp_new_value,
   output logic [7:0] rsp_old_value,
   output logic       rsp_old_known,
   output logic       rsp_changed,
   output logic       rsp_is_status,
   output logic [2:0] rsp_prog_status
);

   import bsc_pkg::*;

   localparam int unsigned DEPTH = 2 * NUM_ADDRESSES;
   localparam int unsigned IDX_W = $clog2(DEPTH);

   // Byte pairing state.
   logic                header_pending_ff;
   logic [7:0]          header_byte_ff;

   // Shadow store: values in a memory, known flags in flops.
   logic [7:0]          shadow_mem [DEPTH];
   logic [DEPTH-1:0]    known_ff;
   logic [DEPTH-1:0]    known_in;

   // Read stage.
   logic                s1_valid_ff;
   logic                s1_bus_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [7:0]          s1_new_ff;
   logic                s1_known_ff;
   logic [7:0]          rd_data_ff;

   // Result register.
   logic                out_valid_ff;
   logic                out_bus_ff;
   logic [ADDR_W-1:0]   out_addr_ff;
   logic [7:0]          out_new_ff;
   logic [7:0]          out_old_ff;
   logic                out_known_ff;
   logic                out_changed_ff;
   logic                out_status_ff;
   prog_status_type     out_prog_ff;

   logic                req_accept;
   logic                s1_advance;
   logic                s1_ready;
   logic                hdr_bus;
   logic [ADDR_W-1:0]   hdr_addr;
   logic                in_range;
   logic                mem_access;
   logic [IDX_W-1:0]    mem_idx;
   logic [7:0]          old_value;
   logic                is_status;

   // Handshake: the read stage moves on when the result register is empty or its item is taken.
   assign s1_advance = !out_valid_ff || !rsp_stall;
   assign s1_ready   = !s1_valid_ff || s1_advance;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && !req_stall;

   // Decode the stored header and the shadow index of the pair.
   assign hdr_bus    = header_byte_ff[BUS_BIT];
   assign hdr_addr   = header_byte_ff[ADDR_W-1:0];
   assign in_range   = {1'b0, hdr_addr} < 8'(NUM_ADDRESSES);
   assign mem_access = req_accept && header_pending_ff && in_range;
   assign mem_idx    = hdr_bus ? IDX_W'(NUM_ADDRESSES) + IDX_W'(hdr_addr)
                               : IDX_W'(hdr_addr);

   // Byte pairing: a header is held until its data byte arrives.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_pending_ff <= 1'b0;
         header_byte_ff    <= 8'd0;
      end else if (req_accept) begin
         header_pending_ff <= !header_pending_ff;
         if (!header_pending_ff) begin
            header_byte_ff <= req_rx_byte;
         end
      end
   end

   // Shadow memory: read the old value and write the new one in the same cycle.
   always_ff @(posedge clock) begin
      if (mem_access) begin
         rd_data_ff          <= shadow_mem[mem_idx];
         shadow_mem[mem_idx] <= req_rx_byte;
      end
   end

   // Known flags: set on every write, cleared by reset.
   always_comb begin
      known_in = known_ff;
      if (mem_access) begin
         known_in[mem_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
      end else begin
         known_ff <= known_in;
      end
   end

   // Read stage: carries the pair while the memory returns the old value.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= mem_access;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_access) begin
         s1_bus_ff   <= hdr_bus;
         s1_addr_ff  <= hdr_addr;
         s1_new_ff   <= req_rx_byte;
         s1_known_ff <= known_ff[mem_idx];
      end
   end

   // Compare the old and new values and decode the status channel.
   assign old_value = s1_known_ff ? rd_data_ff : 8'd0;
   assign is_status = !s1_bus_ff && (s1_addr_ff == STATUS_ADDR);

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         out_bus_ff     <= s1_bus_ff;
         out_addr_ff    <= s1_addr_ff;
         out_new_ff     <= s1_new_ff;
         out_old_ff     <= old_value;
         out_known_ff   <= s1_known_ff;
         out_changed_ff <= !s1_known_ff || (old_value != s1_new_ff);
         out_status_ff  <= is_status;
         out_prog_ff    <= is_status ? decode_status(s1_new_ff) : PROG_IDLE;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_bus_sel     = out_bus_ff;
   assign rsp_address     = out_addr_ff;
   assign rsp_new_value   = out_new_ff;
   assign rsp_old_value   = out_old_ff;
   assign rsp_old_known   = out_known_ff;
   assign rsp_changed     = out_changed_ff;
   assign rsp_is_status   = out_status_ff;
   assign rsp_prog_status = out_prog_ff;

   // An in-range data byte always enters the read stage.
   assert property (@(posedge clock) disable iff (reset)
      mem_access |=> s1_valid_ff)
      else $error("in-range pair did not enter the read stage");

   // A held read stage keeps the memory read data.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> $stable(rd_data_ff))
      else $error("read data changed while the read stage was held");

   // An unknown old entry always reports a change and a zero old value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_old_known) |-> (rsp_changed && (rsp_old_value == 8'd0)))
      else $error("unknown entry reported without a change");

   // Status results only come from the status channel.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_prog_status != PROG_IDLE)) |-> rsp_is_status)
      else $error("status code outside the status channel");

endmodule

@@ tb/sv/bus_shadow_change_monitor_tb.sv @@
// Self-checking testbench for the bus shadow change monitor: directed table, random pairs.
`timescale 1ns / 1ps

module bus_shadow_change_monitor_tb;
   import bsc_pkg::*;

   localparam int unsigned SHADOW_DEPTH = 112;
   localparam int unsigned RANDOM_PAIRS = 213;
   localparam int unsigned DRAIN_CYCLES = 6;

   // One change report as it leaves the block.
   typedef struct packed {
      logic              bus_sel;
      logic [ADDR_W-1:0] address;
      logic [7:0]        new_value;
      logic [7:0]        old_value;
      logic              old_known;
      logic              changed;
      logic              is_status;
      prog_status_type   prog_status;
   } change_rec_type;

   // One row of the directed table; fixed rows carry their report typed in.
   typedef struct packed {
      logic [7:0]     rx_byte;
      logic           fixed;
      change_rec_type want;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [7:0]        req_rx_byte;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_bus_sel;
   logic [6:0]        rsp_address;
   logic [7:0]        rsp_new_value;
   logic [7:0]        rsp_old_value;
   logic              rsp_old_known;
   logic              rsp_changed;
   logic              rsp_is_status;
   logic [2:0]        rsp_prog_status;

   // Predictor state: byte pairing and one shadow store per bus.
   bit                hdr_pending;
   logic [7:0]        hdr_byte;
   logic [7:0]        shadow_val [2][SHADOW_DEPTH];
   bit                shadow_known [2][SHADOW_DEPTH];

   change_rec_type    change_q [$];
   stim_row_type      dir_rows [$];
   int unsigned       mismatch_cnt;
   bit                quiet_phase;

   bus_shadow_change_monitor #(
      .NUM_ADDRESSES(SHADOW_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_bus_sel(rsp_bus_sel),
      .rsp_address(rsp_address),
      .rsp_new_value(rsp_new_value),
      .rsp_old_value(rsp_old_value),
      .rsp_old_known(rsp_old_known),
      .rsp_changed(rsp_changed),
      .rsp_is_status(rsp_is_status),
      .rsp_prog_status(rsp_prog_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap length: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Advance the pairing with one accepted byte; returns 1 when a report is due.
   function automatic bit shadow_predict(input logic [7:0] b, output change_rec_type rec);
      logic              bus;
      logic [ADDR_W-1:0] adr;
      rec = '0;
      if (!hdr_pending) begin
         hdr_byte    = b;
         hdr_pending = 1'b1;
         return 1'b0;
      end
      hdr_pending = 1'b0;
      bus = hdr_byte[BUS_BIT];
      adr = hdr_byte[ADDR_W-1:0];
      if (adr >= SHADOW_DEPTH) begin
         return 1'b0;
      end
      rec.bus_sel   = bus;
      rec.address   = adr;
      rec.new_value = b;
      rec.old_known = shadow_known[bus][adr];
      rec.old_value = rec.old_known ? shadow_val[bus][adr] : 8'd0;
      rec.changed   = !rec.old_known || (rec.old_value != b);
      rec.is_status = (bus == 1'b0) && (adr == STATUS_ADDR);
      rec.prog_status = PROG_IDLE;
      if (rec.is_status && b >= 8'd1 && b <= 8'd4) begin
         rec.prog_status = prog_status_type'(b[2:0]);
      end
      shadow_val[bus][adr]   = b;
      shadow_known[bus][adr] = 1'b1;
      return 1'b1;
   endfunction

   // Append one row to the directed table.
   task automatic add_row(input logic [7:0] b, input logic fixed, input change_rec_type want);
      stim_row_type row;
      row.rx_byte = b;
      row.fixed   = fixed;
      row.want    = want;
      dir_rows.insert(dir_rows.size(), row);
   endtask

   // Queue one expected report behind the ones already waiting.
   task automatic expect_item(input change_rec_type rec);
      change_q.insert(change_q.size(), rec);
   endtask

   // Present one byte from a falling edge and hold it until it is taken.
   task automatic send_rx_byte(input logic [7:0] b);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (req_stall);
   endtask

   // Receiver side: random stall runs changed at the falling edge.
   initial begin
      int unsigned run_left;
      int unsigned len;
      rsp_stall = 1'b0;
      run_left  = 0;
      forever begin
         @(negedge clock);
         if (run_left != 0) begin
            run_left--;
         end else begin
            len = pick_gap();
            if (len == 0) begin
               rsp_stall = 1'b0;
               run_left  = $urandom_range(0, 6);
            end else begin
               rsp_stall = 1'b1;
               run_left  = len - 1;
            end
         end
      end
   end

   // Compare every accepted report with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      change_rec_type seen;
      change_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_bus_sel, rsp_address, rsp_new_value, rsp_old_value,
                 rsp_old_known, rsp_changed, rsp_is_status,
                 prog_status_type'(rsp_prog_status)};
         if (change_q.size() == 0) begin
            $error("unexpected item: bus %0d address %0d value %0d",
                   seen.bus_sel, seen.address, seen.new_value);
            mismatch_cnt++;
         end else begin
            want = change_q.pop_front();
            if (seen !== want) begin
               mismatch_cnt++;
            end
            if (seen.bus_sel !== want.bus_sel)
               $error("bus_sel: expected %0d, actual %0d", want.bus_sel, seen.bus_sel);
            if (seen.address !== want.address)
               $error("address: expected %0d, actual %0d", want.address, seen.address);
            if (seen.new_value !== want.new_value)
               $error("new_value: expected %0d, actual %0d", want.new_value, seen.new_value);
            if (seen.old_value !== want.old_value)
               $error("old_value: expected %0d, actual %0d", want.old_value, seen.old_value);
            if (seen.old_known !== want.old_known)
               $error("old_known: expected %0d, actual %0d", want.old_known, seen.old_known);
            if (seen.changed !== want.changed)
               $error("changed: expected %0d, actual %0d", want.changed, seen.changed);
            if (seen.is_status !== want.is_status)
               $error("is_status: expected %0d, actual %0d", want.is_status, seen.is_status);
            if (seen.prog_status !== want.prog_status)
               $error("prog_status: expected %0d, actual %0d",
                      want.prog_status, seen.prog_status);
         end
      end
   end

   // Stimulus: directed table first, then random header and data pairs.
   initial begin
      change_rec_type    rec;
      logic              bus;
      logic [ADDR_W-1:0] adr;
      logic [7:0]        data;
      int unsigned       r;
      bit                due;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_rx_byte  = 8'd0;
      mismatch_cnt = 0;
      quiet_phase  = 1'b1;
      hdr_pending  = 1'b0;
      hdr_byte     = 8'd0;
      foreach (shadow_known[i, j]) begin
         shadow_known[i][j] = 1'b0;
         shadow_val[i][j]   = 8'd0;
      end

      // Fresh entry at the lowest address, then the same value again.
      add_row(8'h00, 1'b0, '0);
      add_row(8'hFF, 1'b1,
         '{1'b0, 7'd0, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b0, PROG_IDLE});
      add_row(8'h00, 1'b0, '0);
      add_row(8'hFF, 1'b1,
         '{1'b0, 7'd0, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, PROG_IDLE});
      // Highest valid address on the second bus.
      add_row(8'hEF, 1'b0, '0);
      add_row(8'h00, 1'b1,
         '{1'b1, 7'd111, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, PROG_IDLE});
      // Addresses past the store are dropped on both buses.
      add_row(8'h70, 1'b0, '0);
      add_row(8'h55, 1'b0, '0);
      add_row(8'hFF, 1'b0, '0);
      add_row(8'hAA, 1'b0, '0);
      // Every status code on the status channel.
      add_row(8'h08, 1'b0, '0);
      add_row(8'h01, 1'b1,
         '{1'b0, 7'd8, 8'h01, 8'h00, 1'b0, 1'b1, 1'b1, PROG_OK});
      add_row(8'h08, 1'b0, '0);
      add_row(8'h02, 1'b1,
         '{1'b0, 7'd8, 8'h02, 8'h01, 1'b1, 1'b1, 1'b1, PROG_RANGE_ERROR});
      add_row(8'h08, 1'b0, '0);
      add_row(8'h03, 1'b1,
         '{1'b0, 7'd8, 8'h03, 8'h02, 1'b1, 1'b1, 1'b1, PROG_INDEX_ERROR});
      add_row(8'h08, 1'b0, '0);
      add_row(8'h04, 1'b1,
         '{1'b0, 7'd8, 8'h04, 8'h03, 1'b1, 1'b1, 1'b1, PROG_BUSY});
      add_row(8'h08, 1'b0, '0);
      add_row(8'h05, 1'b0, '0);
      // Same address on the second bus is not the status channel.
      add_row(8'h88, 1'b0, '0);
      add_row(8'h01, 1'b1,
         '{1'b1, 7'd8, 8'h01, 8'h00, 1'b0, 1'b1, 1'b0, PROG_IDLE});
      add_row(8'h08, 1'b0, '0);
      add_row(8'h00, 1'b0, '0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table; the first rows run back to back.
      foreach (dir_rows[k]) begin
         quiet_phase = (k < 6);
         send_rx_byte(dir_rows[k].rx_byte);
         due = shadow_predict(dir_rows[k].rx_byte, rec);
         if (dir_rows[k].fixed) begin
            expect_item(dir_rows[k].want);
         end else if (due) begin
            expect_item(rec);
         end
         @(negedge clock);
      end

      // Random pairs aimed at a few hot entries so values repeat and change.
      for (int unsigned p = 0; p < RANDOM_PAIRS; p++) begin
         quiet_phase = (p % 70) < 15;
         bus = 1'($urandom_range(0, 1));
         r   = $urandom_range(0, 99);
         if (r < 45) begin
            adr = 7'($urandom_range(0, 9));
         end else if (r < 55) begin
            bus = 1'b0;
            adr = STATUS_ADDR;
         end else if (r < 85) begin
            adr = 7'($urandom_range(0, SHADOW_DEPTH - 1));
         end else begin
            adr = 7'($urandom_range(SHADOW_DEPTH, 127));
         end
         if (adr < SHADOW_DEPTH && shadow_known[bus][adr] && $urandom_range(0, 99) < 40) begin
            data = shadow_val[bus][adr];
         end else if (bus == 1'b0 && adr == STATUS_ADDR) begin
            data = 8'($urandom_range(0, 6));
         end else begin
            data = 8'($urandom_range(0, 255));
         end
         send_rx_byte({bus, adr});
         due = shadow_predict({bus, adr}, rec);
         @(negedge clock);
         send_rx_byte(data);
         due = shadow_predict(data, rec);
         if (due) begin
            expect_item(rec);
         end
         @(negedge clock);
      end
      req_valid = 1'b0;

      // Drain outstanding reports, then allow for anything still in flight.
      while (change_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0 && change_q.size() == 0) begin
         $display("PASS bus_shadow_change_monitor");
      end else begin
         $display("FAIL bus_shadow_change_monitor");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("FAIL bus_shadow_change_monitor");
      $finish;
   end

endmodule
